// ----- hdl/pdw_pkg.sv -----
// ---------------------------------------------------------------------------
// pdw_pkg
// Shared types and constants of the duplicate packet filter: the layout of
// one fingerprint slot and the status that the slot checker returns.
// ---------------------------------------------------------------------------
package pdw_pkg;

  localparam int unsigned CACHE_DEPTH_DEFAULT = 16;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TIME_W = 64;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 64'd1000000000;

  // One stored fingerprint together with the time at which it was stored.
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [WORD_W-1:0] check;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] signature;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

  // Verdict on one slot: aged out, or a fingerprint match.
  typedef struct packed {
    logic expired;
    logic hit;
  } slot_status_t;

endpackage

// ----- hdl/pdw_slot_ram.sv -----
// ---------------------------------------------------------------------------
// pdw_slot_ram
// Fingerprint store: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module pdw_slot_ram #(
  parameter int unsigned DEPTH = pdw_pkg::CACHE_DEPTH_DEFAULT,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  pdw_pkg::slot_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output pdw_pkg::slot_entry_t rd_data
);

  pdw_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/pdw_slot_check.sv -----
// ---------------------------------------------------------------------------
// pdw_slot_check
// Ages one slot against the current time and compares its fingerprint.
// ---------------------------------------------------------------------------
module pdw_slot_check (
  input  pdw_pkg::slot_entry_t        entry,
  input  pdw_pkg::slot_entry_t        key,
  input  logic [pdw_pkg::TIME_W-1:0]  window,
  output pdw_pkg::slot_status_t       status
);

  logic [pdw_pkg::TIME_W-1:0] age;

  // The age only counts when time has moved forward past the stored stamp.
  assign age = key.stamp - entry.stamp;

  assign status.expired = (key.stamp > entry.stamp) && (age > window);
  assign status.hit     = (entry.mac == key.mac) && (entry.check == key.check) &&
                          (entry.length == key.length) &&
                          (entry.signature == key.signature);

endmodule

// ----- hdl/packet_dedup_window_cache_core.sv -----
// ---------------------------------------------------------------------------
// packet_dedup_window_cache_core
// From acceptance to the result word: the first read issues at the accepting
// edge, one slot is evaluated per cycle in the scan state, then the finish
// state makes the decision and writes back; a match ends the scan early.
// A new word is taken only in the idle state, once the previous word has
// left the finish state. A stalled result word holds the input.
// Reset clears valid bits and write pointer and restores the default window.
// ---------------------------------------------------------------------------
module packet_dedup_window_cache_core #(
  parameter int unsigned CACHE_DEPTH = pdw_pkg::CACHE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [pdw_pkg::TIME_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pdw_pkg::MAC_W-1:0]  source_mac,
  input  logic [pdw_pkg::WORD_W-1:0] frame_check,
  input  logic [pdw_pkg::WORD_W-1:0] payload_length,
  input  logic [pdw_pkg::WORD_W-1:0] frame_signature,
  input  logic [pdw_pkg::TIME_W-1:0] current_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       drop
);

  localparam int unsigned ADDR_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CACHE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state;
  logic [CACHE_DEPTH-1:0]     slot_valid;
  logic [ADDR_W-1:0]          write_pointer;
  logic [ADDR_W-1:0]          eval_idx;
  logic [pdw_pkg::TIME_W-1:0] expiry_window;
  logic                       hit;
  pdw_pkg::slot_entry_t       key;

  pdw_pkg::slot_entry_t  rd_data;
  pdw_pkg::slot_status_t status;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic                  out_free;
  logic                  found;
  logic                  accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A valid, unexpired slot whose fingerprint matches ends the scan.
  assign found = (state == ST_SCAN) && slot_valid[eval_idx] && !status.expired &&
                 status.hit;

  // Reads run one slot ahead of the evaluation.
  assign rd_en   = accept || ((state == ST_SCAN) && !found && (eval_idx != LAST_IDX));
  assign rd_addr = (state == ST_IDLE) ? '0 : eval_idx + 1'b1;
  assign wr_en   = (state == ST_FINISH) && out_free && !hit;

  pdw_slot_ram #(
    .DEPTH (CACHE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pointer),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pdw_slot_check u_check (
    .entry  (rd_data),
    .key    (key),
    .window (expiry_window),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_valid    <= '0;
      write_pointer <= '0;
      eval_idx      <= '0;
      expiry_window <= pdw_pkg::WINDOW_RESET;
      out_valid     <= 1'b0;
      hit           <= 1'b0;
    end else begin
      if (cfg_write) begin
        expiry_window <= cfg_data;
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            eval_idx <= '0;
            hit      <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot_valid[eval_idx] && status.expired) begin
            slot_valid[eval_idx] <= 1'b0;
          end
          if (found) begin
            hit   <= 1'b1;
            state <= ST_FINISH;
          end else if (eval_idx == LAST_IDX) begin
            state <= ST_FINISH;
          end else begin
            eval_idx <= eval_idx + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (!hit) begin
              slot_valid[write_pointer] <= 1'b1;
              if (write_pointer == LAST_IDX) begin
                write_pointer <= '0;
              end else begin
                write_pointer <= write_pointer + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: the fingerprint under test and the result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      key.mac       <= source_mac;
      key.check     <= frame_check;
      key.length    <= payload_length;
      key.signature <= frame_signature;
      key.stamp     <= current_time;
    end
    if ((state == ST_FINISH) && out_free) begin
      drop <= hit;
    end
  end

endmodule
